FILE: src/double_ended_queue_top_macros.svh
// Assertion macros shared by the double-ended queue RTL.
// Included by the top level; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("double-ended queue check failed");

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double-ended queue check failed");

`endif

FILE: src/deq_pkg.sv
// Package of the double-ended queue: field widths, opcodes, status codes
// and the command struct broadcast to the storage cells. No dependencies.
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_WIDTH   = 3;
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 6;
   localparam int COUNT_WIDTH    = 7;
   localparam int STATUS_WIDTH   = 2;

   // Operation codes carried in the request beat.
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR      = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ       = 3'd5;
   localparam logic [OPCODE_WIDTH-1:0] OP_WRITE      = 3'd6;

   // Status codes returned in the response beat.
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_in;   // every cell takes its front neighbor, cell 0 the new value
      logic shift_out;  // every cell but the last takes its back neighbor, the last holds
      logic write;      // the cell at the target index takes the new value
   } cell_cmd_type;

endpackage

FILE: src/deq_if.sv
// Channel interfaces of the double-ended queue: request and response.
// Depends on deq_pkg for the field widths.
interface deq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [deq_pkg::OPCODE_WIDTH-1:0]       opcode;
   logic signed [deq_pkg::VALUE_WIDTH-1:0] value_in;
   logic [deq_pkg::POSITION_WIDTH-1:0]     position;

   modport source (output valid, output opcode, output value_in, output position,
                   input ready);
   modport sink (input valid, input opcode, input value_in, input position,
                 output ready);
endinterface

interface deq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [deq_pkg::VALUE_WIDTH-1:0] value_out;
   logic [deq_pkg::COUNT_WIDTH-1:0]        element_count;
   logic                                   is_empty;
   logic [deq_pkg::STATUS_WIDTH-1:0]       status;

   modport source (output valid, output value_out, output element_count,
                   output is_empty, output status, input ready);
   modport sink (input valid, input value_out, input element_count,
                 input is_empty, input status, output ready);
endinterface

FILE: src/deq_cell.sv
// One storage cell of the queue chain: holds the element at one index
// from the front and relays read data toward the front. Depends on deq_pkg.
module deq_cell #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  deq_pkg::cell_cmd_type        cmd,
   input  logic [$clog2(DEPTH)-1:0]     target,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [DATA_WIDTH-1:0]        front_data,
   input  logic [DATA_WIDTH-1:0]        back_data,
   input  logic [DATA_WIDTH-1:0]        back_relay,
   output logic [DATA_WIDTH-1:0]        data_q,
   output logic [DATA_WIDTH-1:0]        relay_q
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] relay_ff, relay_in;
   logic                  hit;

   assign hit = (target == MY_INDEX);

   // Element update: shift with the chain or take a targeted write.
   always_comb begin
      data_in = data_ff;
      if (cmd.shift_in) begin
         data_in = front_data;
      end else if (cmd.shift_out) begin
         data_in = back_data;
      end else if (cmd.write && hit) begin
         data_in = wr_data;
      end
   end

   // Read relay: the targeted cell injects its element, the others pass along.
   assign relay_in = hit ? data_ff : back_relay;

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      relay_ff <= relay_in;
   end

   assign data_q  = data_ff;
   assign relay_q = relay_ff;

endmodule

FILE: src/double_ended_queue_top.sv
// Bounded double-ended queue of DEPTH elements held in a chain of cells, cell i
// holding the element at index i from the front. Push front, push back, pop front,
// clear and write at an index are answered directly, and the next request is taken
// once the response register is free. Pop back and read at index k wait in a busy
// state: the chosen cell's element moves one cell per cycle along the read relay
// chain to the front before it is registered as the response.
// Depends on deq_pkg, deq_if.sv, deq_cell and double_ended_queue_top_macros.svh.
`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int PW   = deq_pkg::POSITION_WIDTH;
   localparam int CMPW = (CW > PW) ? CW : PW;
   localparam int VW   = deq_pkg::VALUE_WIDTH;

   localparam logic [deq_pkg::COUNT_WIDTH-1:0] COUNT_FULL = deq_pkg::COUNT_WIDTH'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   // Control state.
   logic                                state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Pending read payload.
   logic [IW-1:0]                       target_ff, target_in;
   logic [deq_pkg::OPCODE_WIDTH-1:0]    op_ff, op_in;
   logic [CW-1:0]                       lat_ff, lat_in;

   // Response register.
   logic signed [VW-1:0]                rsp_value_ff, rsp_value_in;
   logic [deq_pkg::COUNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;
   logic                                rsp_empty_ff, rsp_empty_in;
   logic [deq_pkg::STATUS_WIDTH-1:0]    rsp_status_ff, rsp_status_in;

   // Cell chain wiring.
   deq_pkg::cell_cmd_type               cmd;
   logic [IW-1:0]                       cell_target;
   logic [DATA_WIDTH-1:0]               wr_data;
   logic [DATA_WIDTH-1:0]               data_q [DEPTH];
   logic [DATA_WIDTH-1:0]               relay_q [DEPTH];
   logic [DATA_WIDTH-1:0]               front_src [DEPTH];
   logic [DATA_WIDTH-1:0]               back_src [DEPTH];
   logic [DATA_WIDTH-1:0]               back_relay [DEPTH];

   logic                                accept;
   logic                                rsp_free;
   logic                                is_full;
   logic                                is_none;
   logic                                lat_done;
   logic [CW-1:0]                       lat_last;
   logic [IW-1:0]                       clamp_idx;
   logic [IW-1:0]                       last_idx;
   logic [CW-1:0]                       count_next;
   logic [CW-1:0]                       count_dec;
   logic                                pop_front_hit;
   logic                                full_beat;
   logic signed [VW-1:0]                front_value;
   logic signed [VW-1:0]                relay_value;

   // Handshake and status decode.
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && rsp_free;
   assign accept       = req_if.valid && req_if.ready;
   assign is_full      = (count_ff == CW'(DEPTH));
   assign is_none      = (count_ff == '0);
   assign lat_last     = CW'(target_ff) + 1'b1;
   assign lat_done     = (lat_ff == lat_last);
   assign count_dec    = count_ff - 1'b1;
   assign last_idx     = IW'(count_dec);
   assign wr_data      = DATA_WIDTH'($unsigned(req_if.value_in));

   // Index at or past the count clamps to the last element.
   always_comb begin
      if (CMPW'(req_if.position) >= CMPW'(count_ff)) begin
         clamp_idx = last_idx;
      end else begin
         clamp_idx = IW'(req_if.position);
      end
   end

   // Stored elements come back sign-extended from DATA_WIDTH bits.
   assign front_value = VW'($signed(data_q[0]));
   assign relay_value = VW'($signed(relay_q[0]));

   // Operation sequencing.
   always_comb begin
      state_in      = state_ff;
      count_next    = count_ff;
      target_in     = target_ff;
      op_in         = op_ff;
      lat_in        = lat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      cmd           = '0;
      cell_target   = target_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = deq_pkg::ST_OK;
               case (req_if.opcode)
                  deq_pkg::OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        cmd.shift_in = 1'b1;
                        count_next   = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        cmd.write   = 1'b1;
                        cell_target = IW'(count_ff);
                        count_next  = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_FRONT: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        rsp_value_in  = front_value;
                        cmd.shift_out = 1'b1;
                        count_next    = count_ff - 1'b1;
                     end
                  end
                  deq_pkg::OP_POP_BACK: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_BUSY;
                        cell_target  = last_idx;
                        target_in    = last_idx;
                        lat_in       = '0;
                        op_in        = req_if.opcode;
                     end
                  end
                  deq_pkg::OP_CLEAR: begin
                     count_next = '0;
                  end
                  deq_pkg::OP_READ: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_BUSY;
                        cell_target  = clamp_idx;
                        target_in    = clamp_idx;
                        lat_in       = '0;
                        op_in        = req_if.opcode;
                     end
                  end
                  deq_pkg::OP_WRITE: begin
                     if (is_none) begin
                        rsp_status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        cmd.write   = 1'b1;
                        cell_target = clamp_idx;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = deq_pkg::COUNT_WIDTH'(count_next);
               rsp_empty_in = (count_next == '0);
            end
         end
         S_BUSY: begin
            // Wait for the relay to reach the front, then register the beat once the response register is free.
            if (!lat_done) begin
               lat_in = lat_ff + 1'b1;
            end else if (rsp_free) begin
               if (op_ff == deq_pkg::OP_POP_BACK) begin
                  count_next = count_ff - 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_value_in  = relay_value;
               rsp_status_in = deq_pkg::ST_OK;
               rsp_count_in  = deq_pkg::COUNT_WIDTH'(count_next);
               rsp_empty_in  = (count_next == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count_in = count_next;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      op_ff         <= op_in;
      lat_ff        <= lat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Response channel.
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.value_out     = rsp_value_ff;
   assign rsp_if.element_count = rsp_count_ff;
   assign rsp_if.is_empty      = rsp_empty_ff;
   assign rsp_if.status        = rsp_status_ff;

   // Chain of cells with neighbor links; the ends see the new value or hold.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_front
         assign front_src[i] = wr_data;
      end else begin : g_front
         assign front_src[i] = data_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_back
         assign back_src[i]   = data_q[i];
         assign back_relay[i] = '0;
      end else begin : g_back
         assign back_src[i]   = data_q[i+1];
         assign back_relay[i] = relay_q[i+1];
      end

      deq_cell #(
         .DEPTH      (DEPTH),
         .DATA_WIDTH (DATA_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .target     (cell_target),
         .wr_data    (wr_data),
         .front_data (front_src[i]),
         .back_data  (back_src[i]),
         .back_relay (back_relay[i]),
         .data_q     (data_q[i]),
         .relay_q    (relay_q[i])
      );
   end

   // Terms for the checks below.
   assign pop_front_hit = accept && (req_if.opcode == deq_pkg::OP_POP_FRONT) && !is_none;
   assign full_beat     = rsp_valid_ff && (rsp_status_ff == deq_pkg::ST_FULL);

   // Checks on count bounds, pop accounting, full status and relay timing.
   `DEQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `DEQ_ASSERT_NEXT(a_pop_front_count, clock, reset, pop_front_hit, count_ff == $past(count_dec))
   `DEQ_ASSERT_IMPL(a_full_status, clock, reset, full_beat, rsp_count_ff == COUNT_FULL)
   `DEQ_ASSERT_IMPL(a_relay_wait, clock, reset, state_ff == S_BUSY, lat_ff <= lat_last)

endmodule
